/* rtl/core/bpc_pkg.sv */
// Package for the barometric pressure compensation block.
// Register indexes, sequencer constants and the divider response type.
// No dependencies.
package bpc_pkg;

  localparam int unsigned CFG_AW = 5;

  localparam logic [2:0] REG_OSS     = 3'd0;
  localparam logic [2:0] REG_AC1_AC2 = 3'd1;
  localparam logic [2:0] REG_AC3_AC4 = 3'd2;
  localparam logic [2:0] REG_AC5_AC6 = 3'd3;
  localparam logic [2:0] REG_B1_B2   = 3'd4;
  localparam logic [2:0] REG_MC_MD   = 3'd5;

  localparam logic MODE_TEMP  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  localparam logic [31:0] K_B6_OFS   = 32'd4000;
  localparam logic [31:0] K_C3038    = 32'd3038;
  localparam logic [31:0] K_CM7357   = 32'hFFFF_E343;
  localparam logic [31:0] K_C3791    = 32'd3791;
  localparam logic [31:0] K_C50000   = 32'd50000;
  localparam logic [31:0] K_C32768   = 32'd32768;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } bpc_div_rsp_t;

endpackage

/* rtl/core/bpc_div.sv */
// Serial restoring divider, unsigned 32/32, one quotient bit per cycle.
// Depends on bpc_pkg.
module bpc_div
  import bpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [31:0]  num,
  input  logic [31:0]  den,
  output bpc_div_rsp_t rsp
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sh;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[31:0], q_r[31]};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

/* rtl/core/barometric_pressure_compensation.sv */
// Top level of the barometric pressure compensation block.
// Depends on bpc_pkg and bpc_div.
//
// Input stream: in_tuser[0] = mode (0 temperature, 1 pressure),
// in_tdata[23:0] = raw reading. Result stream: out_tdata = signed value
// (0.1 degree or pascals), out_tuser[0] = kind, out_tuser[1] = status
// (divide by zero, value forced to 0).
// Calibration and oversampling sit on the APB port at byte address 4*index;
// write them only while the block is idle.
// One item is worked at a time by a small sequencer around one shared
// 32x32 multiplier and a one-bit-per-cycle divider. A zero divisor skips
// the divider, for temperature and for pressure. in_tready is high only
// while the sequencer is idle and returns in the same cycle in which the
// result is loaded into the output register.
// A finished result is held in the output register; if the receiver stalls,
// the sequencer waits with the next result until the register is free.
// Reset clears the calibration registers, the kept B5 term and all control.
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // [23:0] raw_reading
  input  logic [0:0]        in_tuser,   // [0] mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] result_value
  output logic [1:0]        out_tuser,  // [0] result_kind, [1] status
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_T0   = 5'd1;
  localparam logic [4:0] ST_T1   = 5'd2;
  localparam logic [4:0] ST_TDIV = 5'd3;
  localparam logic [4:0] ST_P0   = 5'd4;
  localparam logic [4:0] ST_P1   = 5'd5;
  localparam logic [4:0] ST_P2   = 5'd6;
  localparam logic [4:0] ST_P3   = 5'd7;
  localparam logic [4:0] ST_P4   = 5'd8;
  localparam logic [4:0] ST_P5   = 5'd9;
  localparam logic [4:0] ST_P6   = 5'd10;
  localparam logic [4:0] ST_P7   = 5'd11;
  localparam logic [4:0] ST_P8   = 5'd12;
  localparam logic [4:0] ST_P9   = 5'd13;
  localparam logic [4:0] ST_PDIV = 5'd14;
  localparam logic [4:0] ST_P11  = 5'd15;
  localparam logic [4:0] ST_P12  = 5'd16;
  localparam logic [4:0] ST_P13  = 5'd17;
  localparam logic [4:0] ST_P14  = 5'd18;
  localparam logic [4:0] ST_P15  = 5'd19;
  localparam logic [4:0] ST_OUT  = 5'd20;

  // configuration
  logic [1:0]  oss_r;
  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r  <= '0;
      ac12_r <= '0;
      ac34_r <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OSS:     oss_r  <= cfg_pwdata[1:0];
        REG_AC1_AC2: ac12_r <= cfg_pwdata;
        REG_AC3_AC4: ac34_r <= cfg_pwdata;
        REG_AC5_AC6: ac56_r <= cfg_pwdata;
        REG_B1_B2:   b12_r  <= cfg_pwdata;
        REG_MC_MD:   mcmd_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OSS:     cfg_prdata = {30'd0, oss_r};
      REG_AC1_AC2: cfg_prdata = ac12_r;
      REG_AC3_AC4: cfg_prdata = ac34_r;
      REG_AC5_AC6: cfg_prdata = ac56_r;
      REG_B1_B2:   cfg_prdata = b12_r;
      REG_MC_MD:   cfg_prdata = mcmd_r;
      default:     cfg_prdata = '0;
    endcase
  end

  // calibration words, extended to 32 bits
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac12_r[31]}}, ac12_r[31:16]};
  assign ac2 = {{16{ac12_r[15]}}, ac12_r[15:0]};
  assign ac3 = {{16{ac34_r[31]}}, ac34_r[31:16]};
  assign ac4 = {16'd0, ac34_r[15:0]};
  assign ac5 = {16'd0, ac56_r[31:16]};
  assign ac6 = {16'd0, ac56_r[15:0]};
  assign b1  = {{16{b12_r[31]}}, b12_r[31:16]};
  assign b2  = {{16{b12_r[15]}}, b12_r[15:0]};
  assign mc  = {{16{mcmd_r[31]}}, mcmd_r[31:16]};
  assign md  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};

  // datapath state
  logic [4:0]  state_r, state_nxt;
  logic [23:0] raw_r, raw_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] b5_r, b5_nxt;
  logic [31:0] t1_r, t1_nxt;
  logic [31:0] b6_r, b6_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [31:0] b3_r, b3_nxt;
  logic [31:0] b4_r, b4_nxt;
  logic [31:0] b7_r, b7_nxt;
  logic        flag_r, flag_nxt;   // quotient negate (temp) or shift (press)
  logic [31:0] res_r, res_nxt;
  logic        st_r, st_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [1:0]  ouser_r, ouser_nxt;

  logic [31:0] mul_a, mul_b, prod;
  logic        div_start;
  logic [31:0] div_num, div_den;
  bpc_div_rsp_t div_rsp;

  logic [31:0] up, den_t, num_t, abs_num, abs_den, qs, tmp, b5v;

  assign prod = mul_a * mul_b;
  assign up   = {8'd0, raw_r} >> (4'd8 - {2'd0, oss_r});
  assign den_t = t1_r + md;
  assign num_t = {mc[20:0], 11'd0};
  assign abs_num = num_t[31] ? (32'd0 - num_t) : num_t;
  assign abs_den = den_t[31] ? (32'd0 - den_t) : den_t;

  bpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt  = state_r;
    raw_nxt    = raw_r;
    kind_nxt   = kind_r;
    b5_nxt     = b5_r;
    t1_nxt     = t1_r;
    b6_nxt     = b6_r;
    sq_nxt     = sq_r;
    b3_nxt     = b3_r;
    b4_nxt     = b4_r;
    b7_nxt     = b7_r;
    flag_nxt   = flag_r;
    res_nxt    = res_r;
    st_nxt     = st_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    qs         = '0;
    tmp        = '0;
    b5v        = '0;

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          raw_nxt   = in_tdata;
          kind_nxt  = in_tuser[0];
          state_nxt = (in_tuser[0] == MODE_TEMP) ? ST_T0 : ST_P0;
        end
      end
      ST_T0: begin
        mul_a     = {16'd0, raw_r[15:0]} - ac6;
        mul_b     = ac5;
        t1_nxt    = $signed(prod) >>> 15;
        state_nxt = ST_T1;
      end
      ST_T1: begin
        if (den_t == 32'd0) begin
          res_nxt   = '0;
          st_nxt    = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = abs_num;
          div_den   = abs_den;
          flag_nxt  = num_t[31] ^ den_t[31];
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (div_rsp.done) begin
          qs        = flag_r ? (32'd0 - div_rsp.quo) : div_rsp.quo;
          b5v       = t1_r + qs;
          b5_nxt    = b5v;
          res_nxt   = $signed(b5v + 32'd8) >>> 4;
          st_nxt    = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_P0: begin
        b6_nxt    = b5_r - K_B6_OFS;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        mul_a     = b6_r;
        mul_b     = b6_r;
        sq_nxt    = $signed(prod) >>> 12;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        mul_a     = b2;
        mul_b     = sq_r;
        t1_nxt    = $signed(prod) >>> 11;
        state_nxt = ST_P3;
      end
      ST_P3: begin
        mul_a     = ac2;
        mul_b     = b6_r;
        tmp       = $signed(prod) >>> 11;
        t1_nxt    = t1_r + tmp;
        state_nxt = ST_P4;
      end
      ST_P4: begin
        tmp       = (({ac1[29:0], 2'd0} + t1_r) << oss_r) + 32'd2;
        b3_nxt    = $signed(tmp) >>> 2;
        state_nxt = ST_P5;
      end
      ST_P5: begin
        mul_a     = ac3;
        mul_b     = b6_r;
        t1_nxt    = $signed(prod) >>> 13;
        state_nxt = ST_P6;
      end
      ST_P6: begin
        mul_a     = b1;
        mul_b     = sq_r;
        tmp       = $signed(prod) >>> 16;
        tmp       = t1_r + tmp + 32'd2;
        t1_nxt    = $signed(tmp) >>> 2;
        state_nxt = ST_P7;
      end
      ST_P7: begin
        mul_a     = ac4;
        mul_b     = t1_r + K_C32768;
        b4_nxt    = prod >> 15;
        state_nxt = ST_P8;
      end
      ST_P8: begin
        mul_a     = up - b3_r;
        mul_b     = K_C50000 >> oss_r;
        b7_nxt    = prod;
        state_nxt = ST_P9;
      end
      ST_P9: begin
        if (b4_r == 32'd0) begin
          res_nxt   = '0;
          st_nxt    = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
          div_den   = b4_r;
          flag_nxt  = b7_r[31];
          state_nxt = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (div_rsp.done) begin
          // b7 now holds p
          b7_nxt    = flag_r ? {div_rsp.quo[30:0], 1'b0} : div_rsp.quo;
          state_nxt = ST_P11;
        end
      end
      ST_P11: begin
        t1_nxt    = $signed(b7_r) >>> 8;
        state_nxt = ST_P12;
      end
      ST_P12: begin
        mul_a     = t1_r;
        mul_b     = t1_r;
        t1_nxt    = prod;
        state_nxt = ST_P13;
      end
      ST_P13: begin
        mul_a     = t1_r;
        mul_b     = K_C3038;
        t1_nxt    = $signed(prod) >>> 16;
        state_nxt = ST_P14;
      end
      ST_P14: begin
        mul_a     = K_CM7357;
        mul_b     = b7_r;
        sq_nxt    = $signed(prod) >>> 16;
        state_nxt = ST_P15;
      end
      ST_P15: begin
        tmp       = t1_r + sq_r + K_C3791;
        tmp       = $signed(tmp) >>> 4;
        res_nxt   = b7_r + tmp;
        st_nxt    = 1'b0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = res_r;
          ouser_nxt  = {st_r, kind_r};
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      b5_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      b5_r     <= b5_nxt;
    end
    raw_r   <= raw_nxt;
    kind_r  <= kind_nxt;
    t1_r    <= t1_nxt;
    b6_r    <= b6_nxt;
    sq_r    <= sq_nxt;
    b3_r    <= b3_nxt;
    b4_r    <= b4_nxt;
    b7_r    <= b7_nxt;
    flag_r  <= flag_nxt;
    res_r   <= res_nxt;
    st_r    <= st_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // one transaction in flight: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_TDIV) || (state_r == ST_PDIV))
    else $error("divider finished outside a wait state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output state");

  a_divzero_value: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && ouser_r[1] |-> odata_r == 32'd0)
    else $error("divide by zero result not zero");

endmodule
